@@ hw/rtl/mmm_pkg.sv @@
// ----------------------------------------------------------------------------
// mmm_pkg - Montgomery multiplier shared types
// Operation codes, register indexes and the record handed along the cell chain.
// ----------------------------------------------------------------------------
package mmm_pkg;

	localparam int unsigned OP_W  = 32;
	localparam int unsigned REG_W = 31;
	localparam int unsigned K_W   = 5;

	typedef enum logic [1:0] {
		KIND_CONV_IN  = 2'd0,
		KIND_MUL      = 2'd1,
		KIND_CONV_OUT = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_NEG_INV = 2'd1,
		REG_R2      = 2'd2,
		REG_R_BITS  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic [OP_W-1:0]    a;
		logic [REG_W-1:0]   b;
		logic [OP_W-1:0]    rem;
	} cell_t;

	typedef struct packed {
		logic [REG_W-1:0] modulus;
		logic [REG_W-1:0] neg_inv;
		logic [REG_W-1:0] r2;
		logic [K_W-1:0]   k;
	} cfg_t;

endpackage

@@ hw/rtl/montgomery_modular_multiplier_core.sv @@
// ----------------------------------------------------------------------------
// montgomery_modular_multiplier_core - pipelined Montgomery multiplier
// Remainder cell chain for convert-in, then a four-stage REDC pipeline.
// ----------------------------------------------------------------------------
// channel | signals                              | transfer
// in      | in_valid/in_ready, kind, operand_a/b | one request per item
// out     | out_valid/out_ready, result          | one request per item
// cfg     | cfg_valid/cfg_ready, cfg_index/data  | one register write
//
// One item per cycle unless the output stalls; items pass 32 remainder cells,
// one bit each, then four REDC stages. Every stage holds one item and its own
// valid bit, so gaps close up while the output stalls. Reset empties the
// pipeline and loads the registers with their defaults; cfg_ready stays high.
module montgomery_modular_multiplier_core #(
	parameter int unsigned MAX_MOD_BITS = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [mmm_pkg::OP_W-1:0]   operand_a,
	input  logic [mmm_pkg::REG_W-1:0]  operand_b,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mmm_pkg::OP_W-1:0]   result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [mmm_pkg::OP_W-1:0]   cfg_data
);
	import mmm_pkg::*;

	cfg_t   cfg_q;
	cell_t  chain_d [OP_W+1];
	logic   chain_v [OP_W+1];
	logic   chain_r [OP_W+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus <= REG_W'(3);
			cfg_q.neg_inv <= REG_W'(1);
			cfg_q.r2      <= REG_W'(1);
			cfg_q.k       <= K_W'(2);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODULUS: cfg_q.modulus <= cfg_data[REG_W-1:0];
				REG_NEG_INV: cfg_q.neg_inv <= cfg_data[REG_W-1:0];
				REG_R2:      cfg_q.r2      <= cfg_data[REG_W-1:0];
				REG_R_BITS:  cfg_q.k       <= cfg_data[K_W-1:0];
				default:     ;
			endcase
		end
	end

	assign chain_v[0]      = in_valid;
	assign chain_d[0].kind = kind_t'(kind);
	assign chain_d[0].a    = operand_a;
	assign chain_d[0].b    = operand_b;
	assign chain_d[0].rem  = '0;
	assign in_ready        = chain_r[0];

	// remainder modulo N, MSB first; a zero modulus passes the operand through
	for (genvar i = 0; i < OP_W; i++) begin : g_cell
		mmm_div_cell #(
			.BIT_POS(OP_W - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_v[i]),
			.in_data  (chain_d[i]),
			.in_ready (chain_r[i]),
			.out_valid(chain_v[i+1]),
			.out_data (chain_d[i+1]),
			.out_ready(chain_r[i+1]),
			.modulus  (cfg_q.modulus)
		);
	end

	mmm_redc #(
		.MAX_MOD_BITS(MAX_MOD_BITS)
	) u_redc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (chain_v[OP_W]),
		.in_data  (chain_d[OP_W]),
		.in_ready (chain_r[OP_W]),
		.out_valid(out_valid),
		.result   (result),
		.out_ready(out_ready)
	);
endmodule

@@ hw/rtl/mmm_div_cell.sv @@
// ----------------------------------------------------------------------------
// mmm_div_cell - one restoring remainder step
// Brings in one operand bit, subtracts the modulus when it fits, registers.
// ----------------------------------------------------------------------------
module mmm_div_cell #(
	parameter int unsigned BIT_POS = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  mmm_pkg::cell_t             in_data,
	output logic                       in_ready,
	output logic                       out_valid,
	output mmm_pkg::cell_t             out_data,
	input  logic                       out_ready,
	input  logic [mmm_pkg::REG_W-1:0]  modulus
);
	import mmm_pkg::*;

	logic          v_q;
	cell_t         d_q;
	cell_t         nxt;
	logic [OP_W:0] sh;
	logic [OP_W:0] diff;

	assign in_ready = !v_q || out_ready;

	always_comb begin
		sh   = {in_data.rem, in_data.a[BIT_POS]};
		diff = sh - {{(OP_W + 1 - REG_W){1'b0}}, modulus};
		nxt  = in_data;
		if (sh >= {{(OP_W + 1 - REG_W){1'b0}}, modulus}) begin
			nxt.rem = diff[OP_W-1:0];
		end else begin
			nxt.rem = sh[OP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;
endmodule

@@ hw/rtl/mmm_redc.sv @@
// ----------------------------------------------------------------------------
// mmm_redc - product and REDC pipeline
// Four stages: operand product, masked N' product, add s*N, shift and correct.
// ----------------------------------------------------------------------------
module mmm_redc #(
	parameter int unsigned MAX_MOD_BITS = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mmm_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	input  mmm_pkg::cell_t            in_data,
	output logic                      in_ready,
	output logic                      out_valid,
	output logic [mmm_pkg::OP_W-1:0]  result,
	input  logic                      out_ready
);
	import mmm_pkg::*;

	localparam logic [K_W-1:0] KMAX = K_W'(MAX_MOD_BITS);

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic                  rdy1, rdy2, rdy3, rdy4;
	logic [2*OP_W-1:0]     x_s1, x_s2, t_s3;
	logic [REG_W-1:0]      s_s2;
	logic [OP_W-1:0]       u_s4;
	logic [2*OP_W-1:0]     x_c, t_c;
	logic [2*REG_W-1:0]    sp_c;
	logic [REG_W-1:0]      s_c;
	logic [K_W-1:0]        k;
	logic [REG_W-1:0]      rmask;
	logic [2*OP_W-1:0]     sh_c;
	logic [OP_W-1:0]       u_c;

	assign k     = (cfg.k > KMAX) ? KMAX : cfg.k;
	assign rmask = ~({REG_W{1'b1}} << k);

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		case (in_data.kind)
			KIND_CONV_IN:  x_c = {{OP_W{1'b0}}, in_data.rem} * {{(OP_W+1){1'b0}}, cfg.r2};
			KIND_MUL:      x_c = {{OP_W{1'b0}}, in_data.a} * {{(OP_W+1){1'b0}}, in_data.b};
			KIND_CONV_OUT: x_c = {{OP_W{1'b0}}, in_data.a};
			default:       x_c = '0;
		endcase
	end

	always_comb begin
		sp_c = {{REG_W{1'b0}}, x_s1[REG_W-1:0] & rmask} * {{REG_W{1'b0}}, cfg.neg_inv};
		s_c  = sp_c[REG_W-1:0] & rmask;
		t_c  = x_s2 + {{(2*OP_W-REG_W){1'b0}}, s_s2} * {{(2*OP_W-REG_W){1'b0}}, cfg.modulus};
		sh_c = t_s3 >> k;
		u_c  = sh_c[OP_W-1:0];
		// one conditional subtraction, wraps if the constants are off
		if ({1'b0, u_c} >= {{(OP_W+1-REG_W){1'b0}}, cfg.modulus}) begin
			u_c = u_c - {{(OP_W-REG_W){1'b0}}, cfg.modulus};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) x_s1 <= x_c;
		if (rdy2 && v_s1) begin
			x_s2 <= x_s1;
			s_s2 <= s_c;
		end
		if (rdy3 && v_s2) t_s3 <= t_c;
		if (rdy4 && v_s3) u_s4 <= u_c;
	end

	assign out_valid = v_s4;
	assign result    = u_s4;
endmodule

@@ hw/rtl/mmm_checker.sv @@
// ----------------------------------------------------------------------------
// mmm_checker - port-level checks for the Montgomery multiplier
// Watches handshakes on the top level; attached by bind.
// ----------------------------------------------------------------------------
module mmm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [mmm_pkg::OP_W-1:0]  result,
	input logic                      cfg_ready
);
	import mmm_pkg::*;

	// empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// no pending result means every stage can take a request
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("stalled result changed");
endmodule

bind montgomery_modular_multiplier_core mmm_checker u_mmm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.result   (result),
	.cfg_ready(cfg_ready)
);
